>>> design/u8v_pkg.sv
// Package for the UTF-8 stream validator: state type and byte class constants.
`default_nettype none
package u8v_pkg;

  localparam int unsigned CodeW = 21;

  localparam logic [7:0] AsciiTop  = 8'h80;
  localparam logic [7:0] Lead2Lo   = 8'hc2;
  localparam logic [7:0] Lead2Hi   = 8'hdf;
  localparam logic [7:0] Lead3Lo   = 8'he0;
  localparam logic [7:0] Lead3Hi   = 8'hef;
  localparam logic [7:0] Lead4Lo   = 8'hf0;
  localparam logic [7:0] Lead4Hi   = 8'hf4;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;

  localparam logic [CodeW-1:0] Min3Byte  = 21'h000800;
  localparam logic [CodeW-1:0] Min4Byte  = 21'h010000;
  localparam logic [CodeW-1:0] MaxCode   = 21'h10ffff;
  localparam logic [CodeW-1:0] SurrLo    = 21'h00d800;
  localparam logic [CodeW-1:0] SurrHi    = 21'h00dfff;

  // Continuation counts of the sequence kinds.
  localparam logic [1:0] SeqNone = 2'd0;
  localparam logic [1:0] Seq2    = 2'd1;
  localparam logic [1:0] Seq3    = 2'd2;
  localparam logic [1:0] Seq4    = 2'd3;

  typedef struct packed {
    logic [1:0]       remaining;
    logic [1:0]       seq_len;
    logic [CodeW-1:0] code;
    logic             failed;
  } state_t;

endpackage
`default_nettype wire

>>> design/u8v_if.sv
// Stream interfaces for the byte input and the verdict output.
`default_nettype none
interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       has_byte;
  logic       last;

  modport source (output valid, output byte_value, output has_byte, output last,
                  input ready);
  modport sink (input valid, input byte_value, input has_byte, input last,
                output ready);
endinterface

interface u8v_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink (input valid, input valid_res, output ready);
endinterface
`default_nettype wire

>>> design/u8v_step.sv
// Next-state logic of the validator for one item.
`default_nettype none
module u8v_step (
  input  wire u8v_pkg::state_t state_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            has_byte_i,
  input  wire logic            last_i,
  output u8v_pkg::state_t      state_o,
  output logic                 valid_res_o
);

  u8v_pkg::state_t taken;
  logic [u8v_pkg::CodeW-1:0] code_n;
  logic [1:0] rem_n;

  always_comb begin
    taken  = state_i;
    code_n = {state_i.code[u8v_pkg::CodeW-7:0], byte_i[5:0]};
    rem_n  = state_i.remaining - 2'd1;
    if (has_byte_i && !state_i.failed) begin
      if (state_i.remaining == 2'd0) begin
        if (byte_i == 8'h00) begin
          taken.failed = 1'b1;
        end else if (byte_i < u8v_pkg::AsciiTop) begin
          taken = state_i;
        end else if (byte_i inside {[u8v_pkg::Lead2Lo:u8v_pkg::Lead2Hi]}) begin
          taken.code      = {16'd0, byte_i[4:0]};
          taken.seq_len   = u8v_pkg::Seq2;
          taken.remaining = u8v_pkg::Seq2;
        end else if (byte_i inside {[u8v_pkg::Lead3Lo:u8v_pkg::Lead3Hi]}) begin
          taken.code      = {17'd0, byte_i[3:0]};
          taken.seq_len   = u8v_pkg::Seq3;
          taken.remaining = u8v_pkg::Seq3;
        end else if (byte_i inside {[u8v_pkg::Lead4Lo:u8v_pkg::Lead4Hi]}) begin
          taken.code      = {18'd0, byte_i[2:0]};
          taken.seq_len   = u8v_pkg::Seq4;
          taken.remaining = u8v_pkg::Seq4;
        end else begin
          taken.failed = 1'b1;
        end
      end else if ((byte_i & u8v_pkg::ContMask) != u8v_pkg::ContTag) begin
        taken.failed = 1'b1;
      end else begin
        taken.code      = code_n;
        taken.remaining = rem_n;
        // Sequence complete: refuse overlong forms, surrogates, out of range.
        if (rem_n == 2'd0) begin
          if ((state_i.seq_len == u8v_pkg::Seq3 && code_n < u8v_pkg::Min3Byte) ||
              (state_i.seq_len == u8v_pkg::Seq4 && code_n < u8v_pkg::Min4Byte) ||
              (code_n > u8v_pkg::MaxCode) ||
              (code_n >= u8v_pkg::SurrLo && code_n <= u8v_pkg::SurrHi)) begin
            taken.failed = 1'b1;
          end
        end
      end
    end
    valid_res_o = !taken.failed && (taken.remaining == 2'd0);
    // Close the string: return to the reset state.
    state_o = last_i ? '0 : taken;
  end

endmodule
`default_nettype wire

>>> design/utf8_stream_validator.sv
// Top level of the streaming strict UTF-8 validator.
// The only feedback loop is the state update; verdicts pass input then result register.
// Throughput: one item per cycle while no verdict is stuck in the result register.
// Input register and result register decouple the two sides, so a waiting result
// does not stop bytes that are not marked last.
// Reset (rst_ni low, asynchronous): both registers empty, checker state cleared.
`default_nettype none
module utf8_stream_validator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  u8v_in_if.sink     in_i,
  u8v_out_if.source  out_o
);

  // Input register: holds one accepted item.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_has_q;
  logic       s1_last_q;

  // Checker state and result register.
  u8v_pkg::state_t state_q, state_d;
  logic            res_valid_q;
  logic            res_q;
  logic            res_d;

  logic s1_adv;
  logic in_take;

  // Advance the held item unless it carries a verdict and the result register is stuck.
  assign s1_adv  = s1_valid_q && (!s1_last_q || !res_valid_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;

  u8v_step u_step (
    .state_i     (state_q),
    .byte_i      (s1_byte_q),
    .has_byte_i  (s1_has_q),
    .last_i      (s1_last_q),
    .state_o     (state_d),
    .valid_res_o (res_d)
  );

  // Input register control; payload loads without reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.byte_value;
      s1_has_q  <= in_i.has_byte;
      s1_last_q <= in_i.last;
    end
  end

  // Commit state and, on the last item, load the verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_q <= state_d;
      end
      if (s1_adv && s1_last_q) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid     = res_valid_q;
  assign out_o.valid_res = res_q;

  // A verdict only ever follows a last item leaving the input register.
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_adv && s1_last_q))
    else $error("result appeared without a closing item");

  // Closing a string returns the checker to its reset state.
  a_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_last_q) |=> (state_q == '0))
    else $error("state not cleared after a string");

  // Pending continuation count never exceeds the sequence length.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.remaining <= state_q.seq_len)
    else $error("remaining count beyond sequence length");

  // An empty input register always takes a new item.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty register");

endmodule
`default_nettype wire
